[rtl/pirl_pkg.sv]
// pirl_pkg: shared constants and types for the positional insert/remove list
// holds list depth, entry and port widths and the per-cycle cell command
// no dependencies
package pirl_pkg;

  // list geometry
  localparam int DEPTH      = 256;
  localparam int ENTRY_BITS = 64;

  // fixed port widths
  localparam int POS_BITS   = 9;

  // derived widths
  localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS   = (POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS;

  // removed-value select tree: cells per group and number of groups
  localparam int GROUP      = 16;
  localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

  // command broadcast to every cell; ins and rem only set for a successful request
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [POS_BITS-1:0]   pos;
    logic [ENTRY_BITS-1:0] value;
  } cmd_t;

endpackage

[rtl/pirl_cell.sv]
// pirl_cell: one list slot of the cell chain
// holds a single entry and takes its neighbour's entry on a shift
// depends on pirl_pkg
module pirl_cell (
  input  logic                            clk,
  input  pirl_pkg::cmd_t                  cmd,
  input  logic [pirl_pkg::IDX_BITS-1:0]   cell_index,
  input  logic [pirl_pkg::ENTRY_BITS-1:0] left_entry,
  input  logic [pirl_pkg::ENTRY_BITS-1:0] right_entry,
  output logic [pirl_pkg::ENTRY_BITS-1:0] entry,
  output logic [pirl_pkg::ENTRY_BITS-1:0] hit_entry
);

  logic [pirl_pkg::CMP_BITS-1:0]   idx_ext;
  logic [pirl_pkg::CMP_BITS-1:0]   pos_ext;
  logic [pirl_pkg::ENTRY_BITS-1:0] entry_next;

  // position compare against this slot
  assign idx_ext = pirl_pkg::CMP_BITS'(cell_index);
  assign pos_ext = pirl_pkg::CMP_BITS'(cmd.pos);

  // shift up on insert, shift down on remove
  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (idx_ext > pos_ext) begin
        entry_next = left_entry;
      end else if (idx_ext == pos_ext) begin
        entry_next = cmd.value;
      end
    end
    if (cmd.rem && (idx_ext >= pos_ext)) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // entry offered to the select tree when it is the one taken out
  assign hit_entry = (cmd.rem && (idx_ext == pos_ext)) ? entry : '0;

endmodule

[rtl/pirl_chain.sv]
// pirl_chain: row of list cells plus the registered select tree
// that picks out the removed entry
// depends on pirl_pkg and pirl_cell
module pirl_chain (
  input  logic                            clk,
  input  pirl_pkg::cmd_t                  cmd,
  input  logic                            cap_en,
  output logic [pirl_pkg::ENTRY_BITS-1:0] removed
);

  logic [pirl_pkg::ENTRY_BITS-1:0] ent [pirl_pkg::DEPTH];
  logic [pirl_pkg::ENTRY_BITS-1:0] hit [pirl_pkg::DEPTH];
  logic [pirl_pkg::ENTRY_BITS-1:0] grp [pirl_pkg::NUM_GROUPS];
  logic [pirl_pkg::ENTRY_BITS-1:0] grp_q [pirl_pkg::NUM_GROUPS];

  // cell row, each cell wired to its neighbours; an end cell takes its own entry on the missing side
  for (genvar i = 0; i < pirl_pkg::DEPTH; i++) begin : g_cell
    logic [pirl_pkg::ENTRY_BITS-1:0] left_e;
    logic [pirl_pkg::ENTRY_BITS-1:0] right_e;

    if (i == 0) begin : g_first
      assign left_e = ent[i];
    end else begin : g_mid_l
      assign left_e = ent[i-1];
    end
    if (i == pirl_pkg::DEPTH - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_mid_r
      assign right_e = ent[i+1];
    end

    pirl_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_index  (pirl_pkg::IDX_BITS'(i)),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (ent[i]),
      .hit_entry   (hit[i])
    );
  end

  // first tree level: or over each group of cells
  for (genvar g = 0; g < pirl_pkg::NUM_GROUPS; g++) begin : g_grp
    always_comb begin
      grp[g] = '0;
      for (int k = 0; k < pirl_pkg::GROUP; k++) begin
        if (g * pirl_pkg::GROUP + k < pirl_pkg::DEPTH) begin
          grp[g] = grp[g] | hit[g * pirl_pkg::GROUP + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cap_en) begin
        grp_q[g] <= grp[g];
      end
    end
  end

  // second tree level: or over the registered groups
  always_comb begin
    removed = '0;
    for (int g = 0; g < pirl_pkg::NUM_GROUPS; g++) begin
      removed = removed | grp_q[g];
    end
  end

endmodule

[rtl/positional_insert_remove_list_top.sv]
// positional insert/remove list, top level
// pipeline: two register stages, first stage then output register; out_stall holds both
// throughput: one transaction per cycle unless stalled; cells shift in the accept cycle
// the removed entry passes a two-level registered or-tree over the cell row
// reset: entry count cleared and pipeline emptied; entry contents are not reset
module positional_insert_remove_list_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [8:0]  position,
  input  logic [63:0] entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [63:0] removed_value,
  output logic [8:0]  entry_count
);

  logic                              accept;
  logic                              ins_ok;
  logic                              rem_ok;
  logic [pirl_pkg::CMP_BITS-1:0]     cnt_ext;
  logic [pirl_pkg::CMP_BITS-1:0]     pos_ext;
  logic [pirl_pkg::COUNT_BITS-1:0]   count;
  logic [pirl_pkg::COUNT_BITS-1:0]   count_next;
  pirl_pkg::cmd_t                    cmd;
  logic [pirl_pkg::ENTRY_BITS-1:0]   removed;
  logic                              a_valid;
  logic                              a_ok;
  logic [pirl_pkg::COUNT_BITS-1:0]   a_count;
  logic                              a_move;

  // pipeline flow
  assign a_move   = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !a_move;
  assign accept   = in_valid && !in_stall;

  // bounds checks
  assign cnt_ext = pirl_pkg::CMP_BITS'(count);
  assign pos_ext = pirl_pkg::CMP_BITS'(position);
  assign ins_ok  = (cnt_ext < pirl_pkg::CMP_BITS'(pirl_pkg::DEPTH)) && (pos_ext <= cnt_ext);
  assign rem_ok  = (count != '0) && (pos_ext < cnt_ext);

  // command to the cell row
  always_comb begin
    cmd.ins   = accept && !mode && ins_ok;
    cmd.rem   = accept && mode && rem_ok;
    cmd.pos   = position;
    cmd.value = pirl_pkg::ENTRY_BITS'(entry_value);
  end

  // entry count
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + pirl_pkg::COUNT_BITS'(1);
    end else if (cmd.rem) begin
      count_next = count - pirl_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  pirl_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .cap_en  (accept),
    .removed (removed)
  );

  // first stage: outcome of the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ok    <= cmd.ins || cmd.rem;
      a_count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      ok            <= a_ok;
      removed_value <= 64'(removed);
      entry_count   <= 9'(a_count);
    end
  end

endmodule

[rtl/pirl_checker.sv]
// pirl_checker: port-level checks on the list result channel
// bound to positional_insert_remove_list_top; depends on pirl_pkg
module pirl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        ok,
  input logic [63:0] removed_value,
  input logic [8:0]  entry_count
);

  logic [8:0] last_count;

  // count carried by the last delivered transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (out_valid && !out_stall) begin
      last_count <= entry_count;
    end
  end

  // a stalled result keeps out_valid, entry_count and ok
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(ok))
    else $error("stalled result changed");

  // a rejected request removes nothing
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> removed_value == 64'd0)
    else $error("rejected request shows a removed value");

  // count never exceeds the list depth
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 9'(pirl_pkg::DEPTH))
    else $error("entry count beyond depth");

  // count moves by one on success and stands still on rejection
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |->
      (ok && ((entry_count == last_count + 9'd1) || (entry_count == last_count - 9'd1)))
      || (!ok && (entry_count == last_count)))
    else $error("entry count step inconsistent with outcome");

  // nothing shown straight after reset
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind positional_insert_remove_list_top pirl_checker u_pirl_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .ok            (ok),
  .removed_value (removed_value),
  .entry_count   (entry_count)
);
